@@ sv/rbms_pkg.sv @@
// rigid body mass setup: shared types, float constants and helpers
// used by the front, queue, reciprocal, back and checker modules
package rbms_pkg;

  localparam int unsigned FP_W   = 32;
  localparam int unsigned MANT_W = 24;
  localparam int unsigned QBITS  = 26;
  localparam int unsigned REM_W  = 25;
  localparam int unsigned RCP_LAT = QBITS + 2;
  localparam int unsigned QDEPTH = 4;

  localparam logic [31:0] MIN_MASS_BITS = 32'h3727_C5AC;
  localparam logic [31:0] INF_MASS_BITS = 32'h5863_5FA9;
  localparam logic [31:0] POS_INF_BITS  = 32'h7F80_0000;
  localparam logic [31:0] QUIET_BIT     = 32'h0040_0000;
  localparam logic [31:0] ONE_BITS      = 32'h3F80_0000;
  localparam logic [31:0] ABS_MASK      = 32'h7FFF_FFFF;
  localparam logic [23:0] LO_MANT       = 24'h83_126F;
  localparam logic [7:0]  LO_EXP        = 8'd117;
  localparam logic [23:0] HI_MANT       = 24'hFA_0000;
  localparam logic [7:0]  HI_EXP        = 8'd136;
  localparam logic [7:0]  EXP_MAX       = 8'hFF;
  localparam logic [7:0]  EXP_BIAS      = 8'd127;

  typedef struct packed {
    logic [31:0] mx;
    logic [31:0] my;
    logic [31:0] mz;
    logic [31:0] mw;
    logic        is_static;
  } body_t;

  typedef struct packed {
    logic              spec;
    logic [31:0]       spec_val;
    logic [23:0]       m;
    logic [24:0]       r;
    logic [25:0]       q;
    logic signed [9:0] e;
  } rcp_t;

  function automatic logic is_nan(input logic [31:0] v);
    return (v[30:23] == EXP_MAX) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic [4:0] lzc23(input logic [22:0] f);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (f[i]) n = 5'(22 - i);
    end
    return n;
  endfunction

endpackage

@@ sv/rbms_front.sv @@
// front part: accepts a body, takes absolute values, classifies static bodies,
// builds the inertia bounds and clamps; uses rbms_pkg
module rbms_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [31:0]          mass_in_i,
  input  logic [31:0]          inertia_xx_i,
  input  logic [31:0]          inertia_yy_i,
  input  logic [31:0]          inertia_zz_i,
  input  logic                 shape_usable_i,
  input  logic                 full_i,
  output logic                 push_o,
  output rbms_pkg::body_t      data_o
);
  import rbms_pkg::*;

  logic        en;
  logic        s1_v_q, s2_v_q;
  logic [31:0] ma_q, ix_q, iy_q, iz_q;
  logic        st_q;
  logic [47:0] plo_q, phi_q;
  body_t       body_q, body_d;
  logic [31:0] ma;
  logic [31:0] lo, hi;
  logic        mnan;

  function automatic logic [31:0] mul_round(input logic [47:0] p, input logic [7:0] ea,
                                            input logic [7:0] ec);
    logic [8:0]  e;
    logic [23:0] man;
    logic        g, s, up;
    e = 9'(ea) + 9'(ec) - 9'(EXP_BIAS) + 9'(p[47]);
    if (p[47]) begin
      man = p[47:24];
      g   = p[23];
      s   = |p[22:0];
    end else begin
      man = p[46:23];
      g   = p[22];
      s   = |p[21:0];
    end
    up = g & (s | man[0]);
    return {1'b0, e[7:0], man[22:0]} + 32'(up);
  endfunction

  function automatic logic [31:0] clamp(input logic [31:0] v, input logic [31:0] l,
                                        input logic [31:0] h, input logic pass);
    logic [31:0] t;
    if (pass || is_nan(v)) begin
      t = v;
    end else if (v > h) begin
      t = h;
    end else if (v < l) begin
      t = l;
    end else begin
      t = v;
    end
    return t;
  endfunction

  assign en         = !(s2_v_q && full_i);
  assign in_stall_o = !en;
  assign push_o     = s2_v_q && !full_i;
  assign data_o     = body_q;
  assign ma         = mass_in_i & ABS_MASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ma_q   <= ma;
      ix_q   <= inertia_xx_i & ABS_MASK;
      iy_q   <= inertia_yy_i & ABS_MASK;
      iz_q   <= inertia_zz_i & ABS_MASK;
      st_q   <= (ma < MIN_MASS_BITS) || !shape_usable_i ||
                ((ma >= INF_MASS_BITS) && (ma <= POS_INF_BITS));
      plo_q  <= {1'b1, ma[22:0]} * LO_MANT;
      phi_q  <= {1'b1, ma[22:0]} * HI_MANT;
      body_q <= body_d;
    end
  end

  always_comb begin
    mnan = is_nan(ma_q);
    lo   = mul_round(plo_q, ma_q[30:23], LO_EXP);
    hi   = mul_round(phi_q, ma_q[30:23], HI_EXP);
    body_d.is_static = st_q;
    if (st_q) begin
      body_d.mx = INF_MASS_BITS;
      body_d.my = INF_MASS_BITS;
      body_d.mz = INF_MASS_BITS;
      body_d.mw = INF_MASS_BITS;
    end else begin
      body_d.mx = clamp(ix_q, lo, hi, mnan);
      body_d.my = clamp(iy_q, lo, hi, mnan);
      body_d.mz = clamp(iz_q, lo, hi, mnan);
      body_d.mw = ma_q;
    end
  end

endmodule

@@ sv/rbms_queue.sv @@
// short queue between front and back parts; holds body_t entries
// uses rbms_pkg
module rbms_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rbms_pkg::body_t data_i,
  input  logic            pop_i,
  output rbms_pkg::body_t data_o,
  output logic            full_o,
  output logic            empty_o
);
  import rbms_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  body_t         mem_q [QDEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

@@ sv/rbms_recip.sv @@
// pipelined single-precision reciprocal, one quotient bit per stage,
// round to nearest even with subnormal results; uses rbms_pkg
module rbms_recip (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  input  logic        zero_i,
  output logic [31:0] y_o
);
  import rbms_pkg::*;

  rcp_t        st_q [QBITS+1];
  rcp_t        st_d [QBITS+1];
  logic [31:0] y_q, y_d;

  always_comb begin
    logic [4:0] lz;
    lz = lzc23(x_i[22:0]);
    st_d[0]          = '0;
    st_d[0].r        = 25'(1) << (MANT_W - 1);
    st_d[0].spec_val = '0;
    if (zero_i) begin
      st_d[0].spec = 1'b1;
    end else if (x_i[30:23] == EXP_MAX) begin
      st_d[0].spec     = 1'b1;
      st_d[0].spec_val = (x_i[22:0] != 23'd0) ? (x_i | QUIET_BIT) : '0;
    end else if (x_i[30:0] == 31'd0) begin
      st_d[0].spec     = 1'b1;
      st_d[0].spec_val = POS_INF_BITS;
    end else if (x_i[30:23] == 8'd0) begin
      st_d[0].m = 24'({x_i[22:0], 1'b0} << lz);
      st_d[0].e = -10'sd127 - $signed({5'b0, lz});
    end else begin
      st_d[0].m = {1'b1, x_i[22:0]};
      st_d[0].e = $signed({2'b0, x_i[30:23]}) - 10'sd127;
    end
    for (int k = 1; k <= QBITS; k++) begin
      logic        b;
      logic [24:0] rs;
      b        = st_q[k-1].r >= {1'b0, st_q[k-1].m};
      rs       = b ? (st_q[k-1].r - {1'b0, st_q[k-1].m}) : st_q[k-1].r;
      st_d[k]   = st_q[k-1];
      st_d[k].r = {rs[23:0], 1'b0};
      st_d[k].q = {st_q[k-1].q[24:0], b};
    end
  end

  always_comb begin
    rcp_t              f;
    logic [25:0]       ext, ext2;
    logic signed [9:0] b;
    logic [7:0]        bexp;
    logic              up;
    f = st_q[QBITS];
    if (f.q[25]) begin
      ext = {f.q[25:2], f.q[1], f.q[0] | (f.r != '0)};
      b   = 10'sd127 - f.e;
    end else begin
      ext = {f.q[24:1], f.q[0], f.r != '0};
      b   = 10'sd126 - f.e;
    end
    bexp = b[7:0];
    ext2 = ext;
    if (b == 10'sd0) begin
      ext2 = {1'b0, ext[25:2], |ext[1:0]};
      bexp = 8'd0;
    end else if (b < 10'sd0) begin
      ext2 = {2'b0, ext[25:3], |ext[2:0]};
      bexp = 8'd0;
    end
    up = ext2[1] & (ext2[0] | ext2[2]);
    if (f.spec) begin
      y_d = f.spec_val;
    end else if (b >= 10'sd255) begin
      y_d = POS_INF_BITS;
    end else begin
      y_d = {1'b0, bexp, ext2[24:2]} + 32'(up);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= QBITS; k++) st_q[k] <= st_d[k];
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

@@ sv/rbms_back.sv @@
// back part: pulls bodies from the queue, runs four reciprocal lanes and
// drives the result register; uses rbms_pkg and rbms_recip
module rbms_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rbms_pkg::body_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [31:0]     mass_x_o,
  output logic [31:0]     mass_y_o,
  output logic [31:0]     mass_z_o,
  output logic [31:0]     mass_w_o,
  output logic [31:0]     inverse_x_o,
  output logic [31:0]     inverse_y_o,
  output logic [31:0]     inverse_z_o,
  output logic [31:0]     inverse_w_o,
  output logic            is_static_o
);
  import rbms_pkg::*;

  logic  en;
  logic  v_q [RCP_LAT];
  body_t side_q [RCP_LAT];

  assign en    = !v_q[RCP_LAT-1] || !out_stall_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RCP_LAT; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= pop_o;
      for (int k = 1; k < RCP_LAT; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= head_i;
      for (int k = 1; k < RCP_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  rbms_recip u_rx (.clk_i, .en_i(en), .x_i(head_i.mx), .zero_i(head_i.is_static),
                   .y_o(inverse_x_o));
  rbms_recip u_ry (.clk_i, .en_i(en), .x_i(head_i.my), .zero_i(head_i.is_static),
                   .y_o(inverse_y_o));
  rbms_recip u_rz (.clk_i, .en_i(en), .x_i(head_i.mz), .zero_i(head_i.is_static),
                   .y_o(inverse_z_o));
  rbms_recip u_rw (.clk_i, .en_i(en), .x_i(head_i.mw), .zero_i(head_i.is_static),
                   .y_o(inverse_w_o));

  assign out_valid_o = v_q[RCP_LAT-1];
  assign mass_x_o    = side_q[RCP_LAT-1].mx;
  assign mass_y_o    = side_q[RCP_LAT-1].my;
  assign mass_z_o    = side_q[RCP_LAT-1].mz;
  assign mass_w_o    = side_q[RCP_LAT-1].mw;
  assign is_static_o = side_q[RCP_LAT-1].is_static;

endmodule

@@ sv/rigid_body_mass_setup_core.sv @@
// path from input transfer to result valid: 2 front stages, the queue memory
// and 28 reciprocal stages incl. the result register
// throughput: one body per cycle unless stalled; one quotient bit per recip stage
// reset: asynchronous, active low; clears all valid bits and queue pointers
module rigid_body_mass_setup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] mass_in_i,
  input  logic [31:0] inertia_xx_i,
  input  logic [31:0] inertia_yy_i,
  input  logic [31:0] inertia_zz_i,
  input  logic        shape_usable_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] mass_x_o,
  output logic [31:0] mass_y_o,
  output logic [31:0] mass_z_o,
  output logic [31:0] mass_w_o,
  output logic [31:0] inverse_x_o,
  output logic [31:0] inverse_y_o,
  output logic [31:0] inverse_z_o,
  output logic [31:0] inverse_w_o,
  output logic        is_static_o
);
  import rbms_pkg::*;

  body_t push_data, head;
  logic  push, pop, full, empty;

  rbms_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mass_in_i, .inertia_xx_i,
    .inertia_yy_i, .inertia_zz_i, .shape_usable_i,
    .full_i(full), .push_o(push), .data_o(push_data)
  );

  rbms_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_data), .pop_i(pop),
    .data_o(head), .full_o(full), .empty_o(empty)
  );

  rbms_back u_back (
    .clk_i, .rst_ni, .head_i(head), .empty_i(empty), .pop_o(pop),
    .out_valid_o, .out_stall_i, .mass_x_o, .mass_y_o, .mass_z_o, .mass_w_o,
    .inverse_x_o, .inverse_y_o, .inverse_z_o, .inverse_w_o, .is_static_o
  );

endmodule

@@ sv/rbms_checker.sv @@
// port-level checks for rigid_body_mass_setup_core and the bind that attaches them
// uses rbms_pkg
module rbms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] mass_w_o,
  input logic [31:0] inverse_x_o,
  input logic [31:0] inverse_y_o,
  input logic [31:0] inverse_z_o,
  input logic [31:0] inverse_w_o,
  input logic        is_static_o
);
  import rbms_pkg::*;

  a_static_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_static_o |-> mass_w_o == INF_MASS_BITS && inverse_x_o == '0 &&
    inverse_y_o == '0 && inverse_z_o == '0 && inverse_w_o == '0)
    else $error("static body result wrong");

  a_dyn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_static_o && mass_w_o <= POS_INF_BITS |->
    mass_w_o >= MIN_MASS_BITS && mass_w_o < INF_MASS_BITS)
    else $error("dynamic mass out of range");

  a_unit_mass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_static_o && mass_w_o == ONE_BITS |-> inverse_w_o == ONE_BITS)
    else $error("reciprocal of one wrong");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(inverse_x_o))
    else $error("stalled transfer changed");

endmodule

bind rigid_body_mass_setup_core rbms_checker u_rbms_checker (.*);
